### design/dda_pkg.sv
// Shared types, constants and control structures for the drift degraded axial spring.
`default_nettype none

package dda_pkg;

	// Field and register widths
	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int KAX_W      = 34;
	localparam int DRIFT_W    = 31;
	localparam int TAN_W      = 35;
	localparam int STRESS_W   = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 34;

	// Datapath widths
	localparam int NUM_W   = DATA_W + 1;            // drift differences
	localparam int MAG_A_W = TAN_W;                 // |k| or |tangent|, at most 2^34
	localparam int MAG_B_W = NUM_W;                 // |n| or |strain|, at most 2^32
	localparam int SPLIT   = (MAG_B_W + 1) / 2;     // multiplier operand split
	localparam int PP_W    = MAG_A_W + SPLIT;
	localparam int HI_W    = MAG_A_W + MAG_B_W - SPLIT;
	localparam int SUM_W   = PP_W + SPLIT;
	localparam int PROD_W  = TAN_W + DATA_W;        // 2^34 * 2^32 fits
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int TERM_W  = 41;                    // capped quotient, up to 2^40
	localparam int TSUM_W  = TERM_W + 2;
	localparam int Q_W     = PROD_W - FRAC_BITS + 1;

	// Tangent and stress limits
	localparam logic signed [TAN_W-1:0] TAN_RIGID = 35'sd9900000000;
	localparam logic signed [TAN_W-1:0] TAN_MAX   = {1'b0, {(TAN_W-1){1'b1}}};
	localparam logic signed [TAN_W-1:0] TAN_MIN   = {1'b1, {(TAN_W-1){1'b0}}};
	localparam logic signed [TAN_W-1:0] TAN_ONE   = 35'sd1;
	localparam logic signed [STRESS_W-1:0] STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
	localparam logic signed [STRESS_W-1:0] STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};
	localparam logic [Q_W-1:0] Q_POS_LIMIT = Q_W'({(STRESS_W-1){1'b1}});
	localparam logic [Q_W-1:0] Q_NEG_LIMIT = Q_W'({1'b1, {(STRESS_W-1){1'b0}}});
	localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

	// Configuration reset values
	localparam logic [KAX_W-1:0]   KAX_RESET = 34'd1000000;
	localparam logic [DRIFT_W-1:0] DSH_RESET = 31'd65536;
	localparam logic [DRIFT_W-1:0] DA_RESET  = 31'd131072;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_STIFFNESS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_DRIFT         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_FAILURE_DRIFT = 2'd2;

	typedef enum logic [1:0] {
		MODE_TRIAL,
		MODE_COMMIT,
		MODE_REVERT_LAST,
		MODE_REVERT_START
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [DATA_W-1:0] strain;
		logic signed [DATA_W-1:0] lateral_drift;
	} in_item_t;

	typedef struct packed {
		logic signed [TAN_W-1:0]    tangent;
		logic signed [STRESS_W-1:0] stress;
		logic                       saturated;
		logic                       divide_fault;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_APPLY,
		ST_KMUL_LO,
		ST_KMUL_HI,
		ST_KMUL_ACC,
		ST_DIV,
		ST_TERM,
		ST_TAN,
		ST_SMAG,
		ST_SMUL_LO,
		ST_SMUL_HI,
		ST_SMUL_ACC,
		ST_STRESS,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic apply;
		logic mul_lo;
		logic mul_hi;
		logic mul_acc;
		logic div_step;
		logic term;
		logic tan;
		logic smag;
		logic stress;
		logic out_load;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_trial;
		logic need_div;
		logic div_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

### design/dda_ctrl.sv
// Sequencing state machine for the drift degraded axial spring.
`default_nettype none

module dda_ctrl import dda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t st,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (!st.is_trial)     state_d = ST_APPLY;
				else if (st.need_div) state_d = ST_KMUL_LO;
				else                  state_d = ST_TERM;
			end
			ST_APPLY:    state_d = ST_DONE;
			ST_KMUL_LO:  state_d = ST_KMUL_HI;
			ST_KMUL_HI:  state_d = ST_KMUL_ACC;
			ST_KMUL_ACC: state_d = ST_DIV;
			ST_DIV: begin
				if (st.div_last) state_d = ST_TERM;
			end
			ST_TERM:     state_d = ST_TAN;
			ST_TAN:      state_d = ST_SMAG;
			ST_SMAG:     state_d = ST_SMUL_LO;
			ST_SMUL_LO:  state_d = ST_SMUL_HI;
			ST_SMUL_HI:  state_d = ST_SMUL_ACC;
			ST_SMUL_ACC: state_d = ST_STRESS;
			ST_STRESS:   state_d = ST_DONE;
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP:    cmd.setup = 1'b1;
			ST_APPLY:    cmd.apply = 1'b1;
			ST_KMUL_LO:  cmd.mul_lo = 1'b1;
			ST_KMUL_HI:  cmd.mul_hi = 1'b1;
			ST_KMUL_ACC: cmd.mul_acc = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_TERM:     cmd.term = 1'b1;
			ST_TAN:      cmd.tan = 1'b1;
			ST_SMAG:     cmd.smag = 1'b1;
			ST_SMUL_LO:  cmd.mul_lo = 1'b1;
			ST_SMUL_HI:  cmd.mul_hi = 1'b1;
			ST_SMUL_ACC: cmd.mul_acc = 1'b1;
			ST_STRESS:   cmd.stress = 1'b1;
			ST_DONE:     cmd.out_load = st.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/dda_dpath.sv
// Datapath: configuration, trial and committed state, shared multiplier, divider and output register.
`default_nettype none

module dda_dpath import dda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_stat_t            st,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	// Configuration
	logic [KAX_W-1:0]   kax_q;
	logic [DRIFT_W-1:0] dsh_q, da_q;

	// Trial and committed state
	logic signed [DATA_W-1:0]   t_strain_q, c_strain_q;
	logic signed [TAN_W-1:0]    t_tan_q, c_tan_q;
	logic signed [STRESS_W-1:0] t_stress_q, c_stress_q;
	logic signed [DATA_W-1:0]   t_peak_q, c_peak_q, t_trough_q, c_trough_q;
	logic signed [DATA_W-1:0]   t_last_q, c_last_q;

	// Per-request working registers
	in_item_t                 item_q;
	logic signed [TAN_W-1:0]  k_q;
	logic                     floor1_q, rigid_q, deg_q, up_q, down_q;
	logic                     fault_q, div_path_q, sat_q;
	logic [DRIFT_W-1:0]       div_q;
	logic [MAG_A_W-1:0]       mag_a_q;
	logic [MAG_B_W-1:0]       mag_b_q;
	logic                     neg_q;
	logic [PP_W-1:0]          mul_pp_s1;
	logic [PP_W-1:0]          mul_acc_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DRIFT_W-1:0]       rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [TERM_W:0]   term_q;
	logic signed [TAN_W-1:0]  tan_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	// Branch decision from the committed state
	logic [DATA_W-1:0]       lt_u, alt, aclt, s_mag;
	logic signed [NUM_W-1:0] dsh_x, n_sel, d_sel;
	logic signed [TAN_W-1:0] k_sel;
	logic                    up, down, rigid, deg_path, ct_gt_k, d_pos;
	logic [MAG_A_W-1:0]      k_mag;
	logic [MAG_B_W-1:0]      n_mag;

	always_comb begin
		lt_u  = item_q.lateral_drift;
		alt   = lt_u[DATA_W-1] ? (~lt_u + 32'd1) : lt_u;
		aclt  = c_last_q[DATA_W-1] ? (~c_last_q + 32'd1) : c_last_q;
		s_mag = item_q.strain[DATA_W-1] ? (~item_q.strain + 32'd1) : item_q.strain;
		dsh_x = $signed({2'b00, dsh_q});
		up    = item_q.lateral_drift > c_peak_q;
		down  = item_q.lateral_drift < c_trough_q;
		rigid = ($signed({c_peak_q[DATA_W-1], c_peak_q}) < dsh_x) &&
		        ($signed({c_trough_q[DATA_W-1], c_trough_q}) > -dsh_x);
		deg_path = !rigid && (up || down);
		ct_gt_k  = $signed({c_tan_q[TAN_W-1], c_tan_q}) > $signed({2'b00, kax_q});
		if (ct_gt_k) begin
			k_sel = $signed({1'b0, kax_q});
			if (up) n_sel = $signed({lt_u[DATA_W-1], lt_u}) - dsh_x;
			else    n_sel = $signed({1'b0, alt}) - dsh_x;
			d_sel = $signed({2'b00, da_q}) - dsh_x;
		end else begin
			k_sel = c_tan_q;
			n_sel = $signed({1'b0, alt}) - $signed({1'b0, aclt});
			d_sel = $signed({2'b00, da_q}) - $signed({1'b0, aclt});
		end
		d_pos = !d_sel[NUM_W-1] && (|d_sel[NUM_W-2:0]);
		k_mag = k_sel[TAN_W-1] ? (~k_sel + 35'd1) : k_sel;
		n_mag = n_sel[NUM_W-1] ? (~n_sel + 33'd1) : n_sel;
	end

	// Shared multiplier, two halves of the narrow operand
	logic [PP_W-1:0]  mul_lo_w;
	logic [HI_W-1:0]  mul_hi_w;
	logic [SUM_W-1:0] mul_sum_w;
	assign mul_lo_w  = mag_a_q * mag_b_q[SPLIT-1:0];
	assign mul_hi_w  = mag_a_q * mag_b_q[MAG_B_W-1:SPLIT];
	assign mul_sum_w = {{SPLIT{1'b0}}, mul_acc_q} + {mul_pp_s1, {SPLIT{1'b0}}};

	// Restoring divider, one quotient bit a cycle, quotient shifts into prod_q
	logic [DRIFT_W:0] div_shift, div_diff;
	logic             div_ge;
	assign div_shift = {rem_q, prod_q[PROD_W-1]};
	assign div_diff  = div_shift - {1'b0, div_q};
	assign div_ge    = div_shift >= {1'b0, div_q};

	// Capped, signed degradation term
	logic              q_over;
	logic [TERM_W-1:0] q_cap;
	assign q_over = (|prod_q[PROD_W-1:TERM_W]) ||
	                (prod_q[TERM_W-1] && (|prod_q[TERM_W-2:0]));
	assign q_cap  = q_over ? TERM_CAP : prod_q[TERM_W-1:0];

	// Tangent clamp and floor
	logic signed [TSUM_W-1:0] t_sum;
	logic                     t_over, t_under;
	logic signed [TAN_W-1:0]  t_clamp, t_floor, t_sel;
	always_comb begin
		t_sum   = $signed({{(TSUM_W-TAN_W){k_q[TAN_W-1]}}, k_q}) -
		          $signed({term_q[TERM_W], term_q});
		t_over  = t_sum > $signed({{(TSUM_W-TAN_W){1'b0}}, TAN_MAX});
		t_under = t_sum < $signed({{(TSUM_W-TAN_W){1'b1}}, TAN_MIN});
		if (t_over)       t_clamp = TAN_MAX;
		else if (t_under) t_clamp = TAN_MIN;
		else              t_clamp = t_sum[TAN_W-1:0];
		t_floor = (floor1_q && (t_clamp < TAN_ONE)) ? TAN_ONE : t_clamp;
		if (rigid_q)    t_sel = TAN_RIGID;
		else if (deg_q) t_sel = t_floor;
		else            t_sel = c_tan_q;
	end

	// Stress: magnitude shifted down, floor for negative results, then saturate
	logic [Q_W-1:0]             q_w;
	logic                       s_round, s_over;
	logic signed [STRESS_W-1:0] stress_w;
	always_comb begin
		s_round = neg_q && (|prod_q[FRAC_BITS-1:0]);
		q_w     = {1'b0, prod_q[PROD_W-1:FRAC_BITS]} + Q_W'(s_round);
		s_over  = neg_q ? (q_w > Q_NEG_LIMIT) : (q_w > Q_POS_LIMIT);
		if (!neg_q) stress_w = s_over ? STRESS_MAX : q_w[STRESS_W-1:0];
		else        stress_w = s_over ? STRESS_MIN : -q_w[STRESS_W-1:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kax_q <= KAX_RESET;
			dsh_q <= DSH_RESET;
			da_q  <= DA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_AXIAL_STIFFNESS:     kax_q <= cfg_wdata;
				CFG_SHEAR_DRIFT:         dsh_q <= cfg_wdata[DRIFT_W-1:0];
				CFG_AXIAL_FAILURE_DRIFT: da_q  <= cfg_wdata[DRIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Trial and committed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_strain_q <= '0;
			c_strain_q <= '0;
			t_tan_q    <= TAN_RIGID;
			c_tan_q    <= TAN_RIGID;
			t_stress_q <= '0;
			c_stress_q <= '0;
			t_peak_q   <= '0;
			c_peak_q   <= '0;
			t_trough_q <= '0;
			c_trough_q <= '0;
			t_last_q   <= '0;
			c_last_q   <= '0;
		end else if (cmd.stress) begin
			t_strain_q <= item_q.strain;
			t_tan_q    <= tan_q;
			t_stress_q <= stress_w;
			t_last_q   <= item_q.lateral_drift;
			if (up_q)   t_peak_q   <= item_q.lateral_drift;
			if (down_q) t_trough_q <= item_q.lateral_drift;
		end else if (cmd.apply) begin
			unique case (item_q.mode)
				MODE_TRIAL: ;
				MODE_COMMIT: begin
					c_strain_q <= t_strain_q;
					c_tan_q    <= t_tan_q;
					c_stress_q <= t_stress_q;
					c_peak_q   <= t_peak_q;
					c_trough_q <= t_trough_q;
					c_last_q   <= t_last_q;
				end
				MODE_REVERT_LAST: begin
					t_strain_q <= c_strain_q;
					t_tan_q    <= c_tan_q;
					t_stress_q <= c_stress_q;
					t_peak_q   <= c_peak_q;
					t_trough_q <= c_trough_q;
					t_last_q   <= c_last_q;
				end
				MODE_REVERT_START: begin
					t_strain_q <= '0;
					c_strain_q <= '0;
					t_tan_q    <= TAN_RIGID;
					c_tan_q    <= TAN_RIGID;
					t_stress_q <= '0;
					c_stress_q <= '0;
					c_peak_q   <= '0;
					c_trough_q <= '0;
					c_last_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// Working registers for the request in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= in_data;
			sat_q   <= 1'b0;
			fault_q <= 1'b0;
		end
		if (cmd.setup) begin
			k_q        <= k_sel;
			floor1_q   <= !ct_gt_k;
			rigid_q    <= rigid;
			deg_q      <= deg_path;
			up_q       <= up;
			down_q     <= down;
			// only a trial request can flag a bad denominator
			fault_q    <= (item_q.mode == MODE_TRIAL) && deg_path && !d_pos;
			div_path_q <= deg_path && d_pos;
			div_q      <= d_sel[DRIFT_W-1:0];
			mag_a_q    <= k_mag;
			mag_b_q    <= n_mag;
			neg_q      <= k_sel[TAN_W-1] != n_sel[NUM_W-1];
		end
		if (cmd.mul_lo) begin
			mul_pp_s1 <= mul_lo_w;
		end
		if (cmd.mul_hi) begin
			mul_acc_q <= mul_pp_s1;
			mul_pp_s1 <= PP_W'(mul_hi_w);
		end
		if (cmd.mul_acc) begin
			prod_q <= mul_sum_w[PROD_W-1:0];
			rem_q  <= '0;
			cnt_q  <= CNT_W'(PROD_W - 1);
		end
		if (cmd.div_step) begin
			rem_q  <= div_ge ? div_diff[DRIFT_W-1:0] : div_shift[DRIFT_W-1:0];
			prod_q <= {prod_q[PROD_W-2:0], div_ge};
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.term) begin
			if (!div_path_q) term_q <= '0;
			else if (neg_q)  term_q <= -$signed({1'b0, q_cap});
			else             term_q <= $signed({1'b0, q_cap});
		end
		if (cmd.tan) begin
			tan_q <= t_sel;
			sat_q <= deg_q && (t_over || t_under);
		end
		if (cmd.smag) begin
			mag_a_q <= tan_q[TAN_W-1] ? (~tan_q + 35'd1) : tan_q;
			mag_b_q <= {1'b0, s_mag};
			neg_q   <= tan_q[TAN_W-1] != item_q.strain[DATA_W-1];
		end
		if (cmd.stress) begin
			sat_q <= sat_q || s_over;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.tangent      <= t_tan_q;
			out_q.stress       <= t_stress_q;
			out_q.saturated    <= sat_q;
			out_q.divide_fault <= fault_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign st.is_trial = item_q.mode == MODE_TRIAL;
	assign st.need_div = deg_path && d_pos;
	assign st.div_last = cnt_q == '0;
	assign st.out_free = !out_valid_q || out_ready;

	// Partial remainder always stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	// A faulted denominator never reaches the divider
	a_fault_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.term |-> !(div_path_q && fault_q))
		else $error("division taken with a faulted denominator");

	// Degradation from the committed tangent never drops below one
	a_floor_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tan && deg_q && floor1_q |=> tan_q > 0)
		else $error("floored tangent below one");

endmodule

`default_nettype wire

### design/drift_degraded_axial_spring.sv
// Top level of the drift degraded axial spring: controller and datapath.
`default_nettype none

// One request at a time. A trial request whose drift passes a committed extreme
// outside the shear drift goes from acceptance to its result in the output
// register through set-up, the low, high and accumulate steps of a shared
// two-pass multiplier, a one-bit-per-cycle restoring divider, and the degradation
// term, tangent, stress multiply and saturation. Other trial requests skip the
// divider; commit and revert requests only move state. A new request is taken
// the cycle after the result is loaded, while that result may still wait on
// out_ready. Configuration writes land at once and are meant for idle periods.
module drift_degraded_axial_spring import dda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t st;

	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	dda_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
